// ===== src/homography_frame_border_max_defines.svh =====
// assertion macros for the homography frame border block
`ifndef HOMOGRAPHY_FRAME_BORDER_MAX_DEFINES_SVH
`define HOMOGRAPHY_FRAME_BORDER_MAX_DEFINES_SVH
`ifndef SYNTHESIS
`define HFB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define HFB_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define HFB_ASSERT(label, clk, rst, prop)
`define HFB_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== src/hfb_pkg.sv =====
// -----------------------------------------------------------------------------
// hfb_pkg
// shared types and constants for the homography frame border block
// -----------------------------------------------------------------------------
package hfb_pkg;
  localparam int CoefW = 48;
  localparam int DimW = 13;
  localparam int OutW = 32;
  localparam int ProdW = 64;
  localparam int FracOut = 16;
  // quotient steps: 62 numerator bits plus 16 fraction bits
  localparam int DivSteps = 78;
  localparam int QW = 52;
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;
  localparam logic [OutW-1:0] IntMin = {1'b1, {(OutW-1){1'b0}}};
  localparam logic [QW-1:0] QCap = QW'(64'd1 << 50);
  localparam logic [QW-1:0] CoordCap = QW'(64'd1 << 47);

  typedef logic signed [CoefW-1:0] coef_t;

  typedef struct packed {
    coef_t [8:0] m;
    logic        last_view;
  } item_t;

  typedef struct packed {
    logic [OutW-1:0] border_top;
    logic [OutW-1:0] border_left;
    logic [OutW-1:0] border_bottom;
    logic [OutW-1:0] border_right;
    logic            degenerate;
  } result_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;      // latch input item
    logic       mac;       // one multiply-add step
    logic [1:0] corner;
    logic [1:0] row;       // 0 x numerator, 1 y numerator, 2 divisor
    logic [1:0] term;      // 0 times x, 1 times y, 2 plus constant
    logic       div_start;
    logic       div_sel;   // 0 x, 1 y
    logic       div_step;
    logic       div_end;   // round and store coordinate
    logic       fold;      // fold corner bounds into running maxima
    logic       emit;      // capture result
  } cmd_t;

  typedef struct packed {
    logic w_zero;
    logic last_view;
  } stat_t;

  // saturate a wide signed value to 32 bits
  function automatic logic [OutW-1:0] sat32(input logic signed [QW+1:0] v);
    logic signed [QW+1:0] hi;
    logic signed [QW+1:0] lo;
    hi = (QW+2)'(64'sh7FFF_FFFF);
    lo = -(QW+2)'(64'sh8000_0000);
    if (v > hi) return {1'b0, {(OutW-1){1'b1}}};
    if (v < lo) return IntMin;
    return v[OutW-1:0];
  endfunction
endpackage

// ===== src/hfb_if.sv =====
// -----------------------------------------------------------------------------
// hfb_if
// valid/ready channel carrying one payload of a given type
// -----------------------------------------------------------------------------
interface hfb_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/hfb_datapath.sv =====
// -----------------------------------------------------------------------------
// hfb_datapath
// shared multiply-add, bit-serial divider and running maxima
// -----------------------------------------------------------------------------
module hfb_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hfb_pkg::DimW-1:0]      frame_width,
  input  logic [hfb_pkg::DimW-1:0]      frame_height,
  input  hfb_pkg::item_t                item,
  input  hfb_pkg::cmd_t                 cmd,
  output hfb_pkg::stat_t                stat,
  output hfb_pkg::result_t              result
);
  localparam int PW = hfb_pkg::ProdW;
  localparam int QW = hfb_pkg::QW;

  hfb_pkg::item_t          held;
  logic signed [PW-1:0]    acc [3];
  logic signed [PW-1:0]    prod;
  logic [PW-1:0]           n_mag;
  logic [PW-1:0]           d_mag;
  logic                    neg;
  logic [PW:0]             rem;
  logic [QW-1:0]           q;
  logic [6:0]              bitpos;
  logic signed [QW+1:0]    px [4];
  logic signed [QW+1:0]    py [4];
  logic signed [QW+1:0]    minx, maxx, miny, maxy;
  logic [hfb_pkg::OutW-1:0] max_top, max_left, max_bottom, max_right;
  logic                    saw_deg;

  // multiplier operands
  logic signed [hfb_pkg::CoefW-1:0] coef;
  logic signed [hfb_pkg::DimW:0]    pos;
  always_comb begin
    coef = held.m[4'(cmd.row) * 4'd3 + 4'(cmd.term)];
    pos = '0;
    unique case (cmd.term)
      2'd0: pos = (cmd.corner == 2'd1 || cmd.corner == 2'd2) ?
                  {1'b0, frame_width} : '0;
      2'd1: pos = (cmd.corner == 2'd2 || cmd.corner == 2'd3) ?
                  {1'b0, frame_height} : '0;
      default: pos = 14'sd1;
    endcase
    prod = PW'(coef) * PW'(pos);
  end

  // multiply-add accumulation
  always_ff @(posedge clk) begin
    if (cmd.load) held <= item;
    if (cmd.mac) begin
      if (cmd.term == 2'd0) acc[cmd.row] <= prod;
      else acc[cmd.row] <= acc[cmd.row] + prod;
    end
  end

  assign stat.w_zero = (acc[2] == '0);
  assign stat.last_view = held.last_view;

  // restoring divider, one quotient bit per cycle
  logic [PW:0]    rem_sh;
  logic           nbit;
  logic [QW-1:0]  q_sh;
  logic [QW-1:0]  q_nx;
  logic [PW:0]    rem_nx;
  always_comb begin
    nbit = (bitpos >= 7'(hfb_pkg::FracOut)) ?
           n_mag[6'(bitpos - 7'(hfb_pkg::FracOut))] : 1'b0;
    rem_sh = {rem[PW-1:0], nbit};
    q_sh = {q[QW-2:0], 1'b0};
    if (rem_sh >= {1'b0, d_mag}) begin
      rem_nx = rem_sh - {1'b0, d_mag};
      q_nx = q_sh | QW'(1);
    end else begin
      rem_nx = rem_sh;
      q_nx = q_sh;
    end
    if (q_nx > hfb_pkg::QCap) q_nx = hfb_pkg::QCap;
  end

  // rounded and clamped quotient
  logic [QW-1:0]        q_rnd;
  logic signed [QW+1:0] coord;
  always_comb begin
    q_rnd = (rem >= ({1'b0, d_mag} - rem)) ? q + QW'(1) : q;
    if (q_rnd > hfb_pkg::CoordCap) q_rnd = hfb_pkg::CoordCap;
    coord = neg ? -$signed({2'b00, q_rnd}) : $signed({2'b00, q_rnd});
  end

  logic [1:0] num_idx;
  assign num_idx = {1'b0, cmd.div_sel};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      n_mag <= acc[num_idx][PW-1] ? -acc[num_idx] : acc[num_idx];
      d_mag <= acc[2][PW-1] ? -acc[2] : acc[2];
      neg <= acc[num_idx][PW-1] ^ acc[2][PW-1];
      rem <= '0;
      q <= '0;
      bitpos <= 7'(hfb_pkg::DivSteps - 1);
    end else if (cmd.div_step) begin
      rem <= rem_nx;
      q <= q_nx;
      bitpos <= bitpos - 7'd1;
    end
    if (cmd.div_end) begin
      if (stat.w_zero) begin
        px[cmd.corner] <= '0;
        py[cmd.corner] <= '0;
      end else if (cmd.div_sel) py[cmd.corner] <= coord;
      else px[cmd.corner] <= coord;
    end
  end

  // corner bounding box
  always_comb begin
    minx = px[0]; maxx = px[0]; miny = py[0]; maxy = py[0];
    for (int k = 1; k < 4; k++) begin
      if (px[k] < minx) minx = px[k];
      if (px[k] > maxx) maxx = px[k];
      if (py[k] < miny) miny = py[k];
      if (py[k] > maxy) maxy = py[k];
    end
  end

  logic [hfb_pkg::OutW-1:0] c_top, c_left, c_bot, c_right;
  assign c_top = hfb_pkg::sat32(-miny);
  assign c_left = hfb_pkg::sat32(-minx);
  assign c_bot = hfb_pkg::sat32(maxy - $signed({(QW+2-29)'(0), frame_height, 16'h0}));
  assign c_right = hfb_pkg::sat32(maxx - $signed({(QW+2-29)'(0), frame_width, 16'h0}));

  function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  // running maxima, cleared after a result
  always_ff @(posedge clk) begin
    if (rst) begin
      max_top <= hfb_pkg::IntMin;
      max_left <= hfb_pkg::IntMin;
      max_bottom <= hfb_pkg::IntMin;
      max_right <= hfb_pkg::IntMin;
      saw_deg <= 1'b0;
    end else if (cmd.emit) begin
      max_top <= hfb_pkg::IntMin;
      max_left <= hfb_pkg::IntMin;
      max_bottom <= hfb_pkg::IntMin;
      max_right <= hfb_pkg::IntMin;
      saw_deg <= 1'b0;
    end else begin
      if (cmd.div_end && cmd.div_sel && stat.w_zero) saw_deg <= 1'b1;
      if (cmd.fold) begin
        max_top <= smax(max_top, c_top);
        max_left <= smax(max_left, c_left);
        max_bottom <= smax(max_bottom, c_bot);
        max_right <= smax(max_right, c_right);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.border_top <= max_top;
      result.border_left <= max_left;
      result.border_bottom <= max_bottom;
      result.border_right <= max_right;
      result.degenerate <= saw_deg;
    end
  end
endmodule

// ===== src/hfb_ctrl.sv =====
// -----------------------------------------------------------------------------
// hfb_ctrl
// sequencer: per corner nine multiply-adds, then two serial divisions
// -----------------------------------------------------------------------------
`include "homography_frame_border_max_defines.svh"
module hfb_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  hfb_pkg::stat_t stat,
  output hfb_pkg::cmd_t  cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC = 3'd1;
  localparam logic [2:0] S_DSTART = 3'd2;
  localparam logic [2:0] S_DIV = 3'd3;
  localparam logic [2:0] S_DEND = 3'd4;
  localparam logic [2:0] S_FOLD = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state, state_next;
  logic [1:0] corner, corner_next;
  logic [1:0] row, row_next;
  logic [1:0] term, term_next;
  logic       sel, sel_next;
  logic [6:0] cnt, cnt_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state; corner_next = corner; row_next = row; term_next = term;
    sel_next = sel; cnt_next = cnt; out_valid_next = out_valid && !out_ready;
    cmd = '0;
    cmd.corner = corner; cmd.row = row; cmd.term = term; cmd.div_sel = sel;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_MAC; corner_next = '0; row_next = '0; term_next = '0;
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (term == 2'd2) begin
          term_next = '0;
          if (row == 2'd2) begin
            row_next = '0; sel_next = 1'b0; state_next = S_DSTART;
          end else row_next = row + 2'd1;
        end else term_next = term + 2'd1;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        cnt_next = 7'(hfb_pkg::DivSteps - 1);
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt - 7'd1;
        if (cnt == '0) state_next = S_DEND;
      end
      S_DEND: begin
        cmd.div_end = 1'b1;
        if (!sel) begin
          sel_next = 1'b1; state_next = S_DSTART;
        end else if (corner == 2'd3) state_next = S_FOLD;
        else begin
          corner_next = corner + 2'd1; state_next = S_MAC;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        state_next = stat.last_view ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        // wait here while the previous result is still held
        if (!out_valid || out_ready) begin
          cmd.emit = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; corner <= '0; row <= '0; term <= '0; sel <= 1'b0;
      cnt <= '0; out_valid <= 1'b0;
    end else begin
      state <= state_next; corner <= corner_next; row <= row_next;
      term <= term_next; sel <= sel_next; cnt <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  // result is raised only after an emit step
  `HFB_ASSERT(a_emit_raises, clk, rst, cmd.emit |=> out_valid)
  // a new result is captured only when the output register is free
  `HFB_ASSERT(a_emit_free, clk, rst, cmd.emit |-> (!out_valid || out_ready))
  // a division start is followed by a divider step
  `HFB_ASSERT(a_div_in_order, clk, rst, cmd.div_start |=> cmd.div_step)
endmodule

// ===== src/homography_frame_border_max.sv =====
// -----------------------------------------------------------------------------
// homography_frame_border_max
// maps frame corners through a homography and tracks border overhang maxima
// -----------------------------------------------------------------------------
//  channel  dir  payload
//  in       in   m00..m22, last_view
//  out      out  border_top/left/bottom/right, degenerate
//  cfg      in   cfg_we, cfg_index, cfg_data (width, height)
// an item runs a load step, per corner nine multiply-adds and two divisions,
// a fold step and, on last, an emit step; the divider's 78 steps per coordinate dominate.
// reset is synchronous; it clears the maxima and restores width 1920, height 1080.
// a pending result holds only the emit step of the next last item until it is taken.
`include "homography_frame_border_max_defines.svh"
module homography_frame_border_max (
  input  logic                         clk,
  input  logic                         rst,
  hfb_if.sink                          in,
  hfb_if.source                        out,
  input  logic                         cfg_we,
  input  logic [hfb_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [hfb_pkg::DimW-1:0]     cfg_data
);
  logic [hfb_pkg::DimW-1:0] frame_width, frame_height;
  hfb_pkg::cmd_t  cmd;
  hfb_pkg::stat_t stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width <= 13'd1920;
      frame_height <= 13'd1080;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hfb_pkg::RegWidth: frame_width <= cfg_data;
        hfb_pkg::RegHeight: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  hfb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
    .out_valid(out.valid), .out_ready(out.ready), .stat(stat), .cmd(cmd)
  );

  hfb_datapath u_dp (
    .clk(clk), .rst(rst), .frame_width(frame_width), .frame_height(frame_height),
    .item(in.data), .cmd(cmd), .stat(stat), .result(out.data)
  );

  // output stays until taken
  `HFB_ASSERT(a_out_hold, clk, rst, out.valid && !out.ready |=> out.valid)
endmodule

// ===== test/tb_homography_frame_border_max.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// tb_homography_frame_border_max
// Drives homographies through the frame border block under several frame
// sizes and checks every emitted border set against a bit-exact predictor
// of the corner mapping, division, saturation and running maxima.
// -----------------------------------------------------------------------------
module tb_homography_frame_border_max;

  localparam int  ItemCycles = 700;      // per-item latency, rounded up
  localparam int  PhaseCount = 5;
  localparam int  RandItems = 1880;
  localparam longint OneQ = 64'sd1 <<< 32;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [hfb_pkg::CfgIdxW-1:0] cfg_index;
  logic [hfb_pkg::DimW-1:0] cfg_data;

  hfb_if #(.payload_t(hfb_pkg::item_t))   in_ch ();
  hfb_if #(.payload_t(hfb_pkg::result_t)) out_ch ();

  homography_frame_border_max DUT (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state and configuration copy
  longint frame_w;
  longint frame_h;
  int run_top, run_left, run_bottom, run_right;
  bit run_degen;

  hfb_pkg::item_t   pending_items[$];
  hfb_pkg::result_t expected_borders[$];
  int      mismatches;
  int      sent_count;
  int      accepted_count;
  bit      pause_sender;
  bit      long_hold;
  bit      long_hold_go;
  int      burst_left, gap_left;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // rounded quotient num * 2^16 / den with clamped magnitude
  function automatic longint proj_div(longint num, longint den);
    longint unsigned n, d, rem, q, b;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    rem = 0;
    q = 0;
    for (int i = 61 + hfb_pkg::FracOut; i >= 0; i--) begin
      b = (i >= hfb_pkg::FracOut) ? ((n >> (i - hfb_pkg::FracOut)) & 1) : 0;
      rem = (rem << 1) | b;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 1;
      end
      if (q > (64'd1 << 50)) q = 64'd1 << 50;
    end
    if (rem >= d - rem) q = q + 1;
    if (q > (64'd1 << 47)) q = 64'd1 << 47;
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return int'(v);
  endfunction

  function automatic int max_of(int a, int b);
    return a > b ? a : b;
  endfunction

  // map the four corners and fold overhangs into the running maxima
  task automatic predict_borders(input hfb_pkg::item_t it);
    longint m[9];
    longint cx[4], cy[4], px[4], py[4];
    longint nx, ny, w, minx, maxx, miny, maxy;
    hfb_pkg::result_t r;
    for (int k = 0; k < 9; k++) m[k] = longint'($signed(it.m[k]));
    cx[0] = 0;       cy[0] = 0;
    cx[1] = frame_w; cy[1] = 0;
    cx[2] = frame_w; cy[2] = frame_h;
    cx[3] = 0;       cy[3] = frame_h;
    for (int k = 0; k < 4; k++) begin
      nx = m[0] * cx[k] + m[1] * cy[k] + m[2];
      ny = m[3] * cx[k] + m[4] * cy[k] + m[5];
      w  = m[6] * cx[k] + m[7] * cy[k] + m[8];
      if (w == 0) begin
        px[k] = 0;
        py[k] = 0;
        run_degen = 1'b1;
      end else begin
        px[k] = proj_div(nx, w);
        py[k] = proj_div(ny, w);
      end
    end
    minx = px[0]; maxx = px[0]; miny = py[0]; maxy = py[0];
    for (int k = 1; k < 4; k++) begin
      if (px[k] < minx) minx = px[k];
      if (px[k] > maxx) maxx = px[k];
      if (py[k] < miny) miny = py[k];
      if (py[k] > maxy) maxy = py[k];
    end
    run_top    = max_of(run_top, clip32(-miny));
    run_left   = max_of(run_left, clip32(-minx));
    run_bottom = max_of(run_bottom, clip32(maxy - (frame_h <<< hfb_pkg::FracOut)));
    run_right  = max_of(run_right, clip32(maxx - (frame_w <<< hfb_pkg::FracOut)));
    if (it.last_view) begin
      r.border_top = run_top;
      r.border_left = run_left;
      r.border_bottom = run_bottom;
      r.border_right = run_right;
      r.degenerate = run_degen;
      expected_borders.push_back(r);
      run_top = hfb_pkg::IntMin; run_left = hfb_pkg::IntMin;
      run_bottom = hfb_pkg::IntMin; run_right = hfb_pkg::IntMin;
      run_degen = 1'b0;
    end
  endtask

  // signed random value within +-2^b
  function automatic longint rand_signed(int b);
    longint v;
    v = {$urandom, $urandom};
    return v >>> (63 - b);
  endfunction

  function automatic hfb_pkg::item_t identity_item(bit last);
    hfb_pkg::item_t it;
    it.m = '0;
    it.m[0] = hfb_pkg::coef_t'(OneQ);
    it.m[4] = hfb_pkg::coef_t'(OneQ);
    it.m[8] = hfb_pkg::coef_t'(OneQ);
    it.last_view = last;
    return it;
  endfunction

  // random homography: mostly plausible views, some raw noise, some degenerate
  function automatic hfb_pkg::item_t random_item(longint w, longint h);
    hfb_pkg::item_t it;
    int kind;
    int c;
    longint cx, cy;
    kind = $urandom_range(0, 19);
    it.last_view = ($urandom_range(0, 3) == 0);
    if (kind < 3) begin
      for (int k = 0; k < 9; k++) it.m[k] = hfb_pkg::coef_t'({$urandom, $urandom});
    end else begin
      it.m[0] = hfb_pkg::coef_t'(OneQ + rand_signed(30));
      it.m[1] = hfb_pkg::coef_t'(rand_signed(29));
      it.m[2] = hfb_pkg::coef_t'(rand_signed(42));
      it.m[3] = hfb_pkg::coef_t'(rand_signed(29));
      it.m[4] = hfb_pkg::coef_t'(OneQ + rand_signed(30));
      it.m[5] = hfb_pkg::coef_t'(rand_signed(42));
      it.m[6] = hfb_pkg::coef_t'(rand_signed($urandom_range(8, 21)));
      it.m[7] = hfb_pkg::coef_t'(rand_signed($urandom_range(8, 21)));
      it.m[8] = hfb_pkg::coef_t'(OneQ + rand_signed(30));
      if (kind < 5) begin
        // force a zero divisor at one corner
        c = $urandom_range(0, 3);
        cx = (c == 1 || c == 2) ? w : 0;
        cy = (c >= 2) ? h : 0;
        it.m[6] = hfb_pkg::coef_t'(rand_signed(30));
        it.m[7] = hfb_pkg::coef_t'(rand_signed(30));
        it.m[8] = hfb_pkg::coef_t'(-(longint'($signed(it.m[6])) * cx +
                                     longint'($signed(it.m[7])) * cy));
      end
    end
    return it;
  endfunction

  // sender: bursts with random gaps, holds an item until it is taken
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      burst_left <= 0;
      gap_left <= 0;
      sent_count <= 0;
    end else if (in_ch.valid && sent_count != accepted_count) begin
      in_ch.valid <= 1'b1;
    end else begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pause_sender || pending_items.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.data <= pending_items.pop_front();
        in_ch.valid <= 1'b1;
        sent_count <= sent_count + 1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 6);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 900);
        end
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off
  always @(negedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else if (long_hold) out_ch.ready <= 1'b0;
    else if (($time / 20000) % 3 == 0) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    long_hold = 1'b0;
    wait (long_hold_go);
    @(negedge clk);
    long_hold = 1'b1;
    repeat (6000) @(negedge clk);
    long_hold = 1'b0;
  end

  // monitor: predict on accepted input, check on accepted result
  always @(posedge clk) begin
    if (rst) begin
      accepted_count <= 0;
      mismatches <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        accepted_count <= accepted_count + 1;
        predict_borders(in_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_borders.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result transaction: %p", out_ch.data);
        end else if (out_ch.data !== expected_borders[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("border mismatch: expected %p actual %p", expected_borders[0],
                     out_ch.data);
          void'(expected_borders.pop_front());
        end else begin
          void'(expected_borders.pop_front());
        end
      end
    end
  end

  task automatic wait_idle();
    wait (pending_items.size() == 0 && !in_ch.valid && expected_borders.size() == 0);
    repeat (ItemCycles) @(negedge clk);
  endtask

  task automatic write_size(input longint w, input longint h);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= hfb_pkg::RegWidth; cfg_data <= hfb_pkg::DimW'(w);
    @(negedge clk);
    cfg_index <= hfb_pkg::RegHeight; cfg_data <= hfb_pkg::DimW'(h);
    @(negedge clk);
    cfg_we <= 1'b0;
    frame_w = w;
    frame_h = h;
  endtask

  // stimulus and end of run
  initial begin
    hfb_pkg::item_t it;
    longint ws[PhaseCount], hs[PhaseCount];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = hfb_pkg::RegWidth;
    cfg_data = '0;
    pause_sender = 1'b0;
    long_hold_go = 1'b0;
    frame_w = 1920;
    frame_h = 1080;
    run_top = hfb_pkg::IntMin; run_left = hfb_pkg::IntMin;
    run_bottom = hfb_pkg::IntMin; run_right = hfb_pkg::IntMin;
    run_degen = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: identity, zero, extremes, zero divisor, huge quotient
    pending_items.push_back(identity_item(1));
    it = '0; it.last_view = 1; pending_items.push_back(it);
    it = '1; pending_items.push_back(it);
    for (int k = 0; k < 9; k++) it.m[k] = {1'b0, {(hfb_pkg::CoefW-1){1'b1}}};
    it.last_view = 1; pending_items.push_back(it);
    for (int k = 0; k < 9; k++) it.m[k] = {1'b1, {(hfb_pkg::CoefW-1){1'b0}}};
    pending_items.push_back(it);
    it = identity_item(0); it.m[8] = '0; pending_items.push_back(it);
    it = identity_item(1); it.m[6] = hfb_pkg::coef_t'(OneQ);
    it.m[8] = hfb_pkg::coef_t'(-(OneQ * 1920));
    pending_items.push_back(it);
    it = identity_item(1); it.m[2] = {1'b0, {(hfb_pkg::CoefW-1){1'b1}}};
    it.m[8] = hfb_pkg::coef_t'(1);
    pending_items.push_back(it);
    it = identity_item(1); it.m[5] = {1'b1, {(hfb_pkg::CoefW-1){1'b0}}};
    it.m[8] = hfb_pkg::coef_t'(-1);
    pending_items.push_back(it);
    it = identity_item(0); it.m[2] = hfb_pkg::coef_t'(OneQ * 50);
    pending_items.push_back(it);
    it = identity_item(0); it.m[5] = hfb_pkg::coef_t'(-OneQ * 30);
    pending_items.push_back(it);
    it = identity_item(1); it.m[0] = hfb_pkg::coef_t'(OneQ * 2);
    it.m[4] = hfb_pkg::coef_t'(OneQ / 2);
    pending_items.push_back(it);
    wait_idle();

    ws[0] = 1;    hs[0] = 1;
    ws[1] = 8191; hs[1] = 8191;
    ws[2] = 0;    hs[2] = 0;
    ws[3] = $urandom_range(1, 8191); hs[3] = $urandom_range(1, 8191);
    ws[4] = 1920; hs[4] = 1080;
    for (int p = 0; p < PhaseCount; p++) begin
      write_size(ws[p], hs[p]);
      for (int i = 0; i < RandItems / PhaseCount; i++)
        pending_items.push_back(random_item(ws[p], hs[p]));
      pending_items.push_back(identity_item(1));
      if (p == 1) begin
        repeat (50) @(negedge clk);
        long_hold_go = 1'b1;
      end
      if (p == 3) begin
        // pause the sender mid-phase until everything has drained
        wait (pending_items.size() < RandItems / PhaseCount / 2);
        pause_sender = 1'b1;
        wait (!in_ch.valid && expected_borders.size() == 0);
        repeat (ItemCycles) @(negedge clk);
        pause_sender = 1'b0;
      end
      wait_idle();
    end

    repeat (ItemCycles) @(negedge clk);
    if (mismatches == 0 && expected_borders.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end
endmodule
